// ===== rtl/tcpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and constants for the three-class priority queue
// Word formats, status codes, cell entry and cell control types.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CAP_W    = 5;
  localparam int OCC_W    = 5;
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [1:0] CLASS_LOWEST = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REMOVED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic                mode;
    logic [TAG_BITS-1:0] entry_tag;
    logic [1:0]          priority_class;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TAG_BITS-1:0] removed_tag;
    logic [1:0]          removed_class;
    logic [OCC_W-1:0]    occupancy;
  } out_word_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          cls;
  } cell_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    cell_entry_t ins_entry;
  } cell_ctrl_t;

endpackage : tcpq_pkg
`default_nettype wire

// ===== rtl/three_class_priority_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// three_class_priority_queue_top: bounded three-class priority queue
// A chain of slot cells kept sorted by class, with arrival order per class.
// ----------------------------------------------------------------------------
// Usage:
//   An input word (insert or remove) is taken at a clock edge where start
//   is high and busy is low. Exactly one result word follows: out_strobe
//   is a one-cycle strobe registered at the accepting edge, with out_word
//   carrying status, removed tag and class, and the new occupancy.
//   A new word can be started every cycle while busy is low; the whole
//   slot chain shifts at once, every cell updating at the accepting edge.
//   cfg_wr_en writes the capacity at any edge; write it only while idle.
//   A capacity above the number of slots acts as the number of slots, and
//   zero refuses every insert.
//   Reset (rst_n low, synchronous) empties the queue, sets the capacity to
//   16 and holds busy high; busy drops in the first cycle after reset.
//   The receiver cannot stall: each result is valid for its one cycle only.
// ----------------------------------------------------------------------------
module three_class_priority_queue_top (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  tcpq_pkg::in_word_t       in_word,
  output logic                     out_strobe,
  output tcpq_pkg::out_word_t      out_word,
  input  wire                      cfg_wr_en,
  input  wire [4:0]                cfg_wr_data
);
  import tcpq_pkg::*;

  logic             busy_r;
  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_strobe_r;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;

  logic        accept;
  logic        full;
  logic        insert_ok;
  logic        remove_ok;
  logic [1:0]  ins_cls;
  cell_ctrl_t  ctrl;

  cell_entry_t     entries [DEPTH];
  logic [DEPTH-1:0] keeps;
  logic [DEPTH-1:0] occupied;

  assign accept = start && !busy_r;

  // Unknown classes fall to the lowest class.
  assign ins_cls = (in_word.priority_class > CLASS_LOWEST) ? CLASS_LOWEST
                                                           : in_word.priority_class;

  assign full = (CMP_W'(count_r) >= CMP_W'(capacity_r)) || (count_r == CNT_W'(DEPTH));
  assign insert_ok = accept && (in_word.mode == MODE_INSERT) && !full;
  assign remove_ok = accept && (in_word.mode == MODE_REMOVE) && (count_r != '0);

  always_comb begin
    ctrl.ins_entry.tag = in_word.entry_tag;
    ctrl.ins_entry.cls = ins_cls;
    priority if (insert_ok) begin
      ctrl.op = OP_INSERT;
    end else if (remove_ok) begin
      ctrl.op = OP_REMOVE;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cell_entry_t left_e;
      cell_entry_t right_e;
      logic        left_k;

      assign occupied[gi] = (CNT_W'(gi) < count_r);

      if (gi == 0) begin : g_head
        assign left_e = ctrl.ins_entry;
        assign left_k = 1'b1;
      end else begin : g_body
        assign left_e = entries[gi-1];
        assign left_k = keeps[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_e = entries[gi];
      end else begin : g_inner
        assign right_e = entries[gi+1];
      end

      tcpq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[gi]),
        .left_keep   (left_k),
        .left_entry  (left_e),
        .right_entry (right_e),
        .entry       (entries[gi]),
        .keep        (keeps[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (insert_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (remove_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end

    out_word_nxt.removed_tag   = '0;
    out_word_nxt.removed_class = '0;
    out_word_nxt.occupancy     = OCC_W'(count_nxt);
    if (in_word.mode == MODE_INSERT) begin
      out_word_nxt.status = full ? ST_FULL : ST_INSERTED;
    end else if (count_r == '0) begin
      out_word_nxt.status = ST_EMPTY;
    end else begin
      out_word_nxt.status        = ST_REMOVED;
      out_word_nxt.removed_tag   = entries[0].tag;
      out_word_nxt.removed_class = entries[0].cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      capacity_r   <= CAP_W'(16);
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      out_strobe_r <= accept;
      count_r      <= count_nxt;
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted word produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_strobe)
    else $error("result without an accepted word");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy beyond slot count");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    insert_ok |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not raise occupancy");

  a_removed_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_word.status == ST_REMOVED)) |-> (out_word.removed_class != 2'd3))
    else $error("removed word carries an invalid class");
`endif

endmodule : three_class_priority_queue_top
`default_nettype wire

// ===== rtl/tcpq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_cell: one slot of the sorted queue chain
// Holds one entry and, per cycle, keeps it, takes the inserted entry,
// takes its left neighbor's entry (shift toward the tail) or its right
// neighbor's entry (shift toward the head).
// ----------------------------------------------------------------------------
module tcpq_cell (
  input  wire                     clk,
  input  tcpq_pkg::cell_ctrl_t    ctrl,
  input  wire                     occupied,
  input  wire                     left_keep,
  input  tcpq_pkg::cell_entry_t   left_entry,
  input  tcpq_pkg::cell_entry_t   right_entry,
  output tcpq_pkg::cell_entry_t   entry,
  output logic                    keep
);
  import tcpq_pkg::*;

  cell_entry_t entry_r;
  cell_entry_t entry_nxt;

  // An occupied cell whose class is of equal or higher priority (equal or lower number) stays in front of the new word.
  assign keep  = occupied && (entry_r.cls <= ctrl.ins_entry.cls);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (keep) begin
          entry_nxt = entry_r;
        end else if (left_keep) begin
          entry_nxt = ctrl.ins_entry;
        end else begin
          entry_nxt = left_entry;
        end
      end
      OP_REMOVE: entry_nxt = right_entry;
      default:   entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule : tcpq_cell
`default_nettype wire

// ===== verif/tb_three_class_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// tb_three_class_priority_queue_top: self-checking bench for the priority queue
// A short directed table covers the empty queue, both modes, the unknown class
// and the order within and across classes. Random phases follow, each under its
// own capacity (zero, one, beyond the store, and below the current occupancy).
// A behavioral copy of the queue predicts every result word that the table does
// not fix by hand, and each result word is checked field by field.
// ----------------------------------------------------------------------------
module tb_three_class_priority_queue_top;
  import tcpq_pkg::*;

  localparam int STALL_LIMIT = 500;
  localparam int DIR_ROWS    = 22;
  localparam int PHASES      = 11;
  localparam int PHASE_WORDS = 64;

  // One directed row: the input word, whether a hand-written result applies,
  // and that result.
  typedef struct packed {
    in_word_t  word;
    logic      fixed;
    out_word_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_strobe;
  out_word_t   out_word;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;

  // Hand-written result for the word on in_word, valid when row_fixed is set.
  logic        row_fixed;
  out_word_t   row_expect;
  logic        idle_on;

  // Behavioral copy of the queue, head first.
  cell_entry_t queue_model[$];
  logic [4:0]  cap_model;
  out_word_t   result_fifo[$];

  int mismatches;
  int stall_cycles;
  int n_words;
  int n_inserted;
  int n_refused;
  int n_removed;
  int n_empty;

  dir_row_t dir_rows [DIR_ROWS] = '{
    {{MODE_REMOVE, 16'hFFFF, 2'd3}, 1'b1, {ST_EMPTY,    16'h0000, 2'd0, 5'd0}},
    {{MODE_INSERT, 16'hFFFF, 2'd2}, 1'b1, {ST_INSERTED, 16'h0000, 2'd0, 5'd1}},
    {{MODE_INSERT, 16'h0000, 2'd0}, 1'b1, {ST_INSERTED, 16'h0000, 2'd0, 5'd2}},
    {{MODE_INSERT, 16'h1234, 2'd3}, 1'b0, 25'd0},
    {{MODE_INSERT, 16'hA5A5, 2'd1}, 1'b0, 25'd0},
    {{MODE_INSERT, 16'h0001, 2'd0}, 1'b0, 25'd0},
    {{MODE_REMOVE, 16'h5A5A, 2'd2}, 1'b1, {ST_REMOVED,  16'h0000, 2'd0, 5'd4}},
    {{MODE_REMOVE, 16'h0000, 2'd0}, 1'b1, {ST_REMOVED,  16'h0001, 2'd0, 5'd3}},
    {{MODE_REMOVE, 16'hFFFF, 2'd1}, 1'b1, {ST_REMOVED,  16'hA5A5, 2'd1, 5'd2}},
    {{MODE_REMOVE, 16'h0000, 2'd3}, 1'b1, {ST_REMOVED,  16'hFFFF, 2'd2, 5'd1}},
    {{MODE_REMOVE, 16'h0000, 2'd0}, 1'b1, {ST_REMOVED,  16'h1234, 2'd2, 5'd0}},
    {{MODE_REMOVE, 16'h0000, 2'd0}, 1'b1, {ST_EMPTY,    16'h0000, 2'd0, 5'd0}},
    {{MODE_INSERT, 16'h0005, 2'd1}, 1'b0, 25'd0},
    {{MODE_INSERT, 16'h0006, 2'd1}, 1'b0, 25'd0},
    {{MODE_INSERT, 16'h0007, 2'd2}, 1'b0, 25'd0},
    {{MODE_INSERT, 16'h0008, 2'd1}, 1'b0, 25'd0},
    {{MODE_INSERT, 16'h0009, 2'd0}, 1'b0, 25'd0},
    {{MODE_REMOVE, 16'h0000, 2'd0}, 1'b0, 25'd0},
    {{MODE_REMOVE, 16'h0000, 2'd0}, 1'b0, 25'd0},
    {{MODE_REMOVE, 16'h0000, 2'd0}, 1'b0, 25'd0},
    {{MODE_REMOVE, 16'h0000, 2'd0}, 1'b0, 25'd0},
    {{MODE_REMOVE, 16'h0000, 2'd0}, 1'b0, 25'd0}
  };

  // Capacity per random phase, and the share of inserts in percent. The phase
  // after the high-fill first one lowers the capacity below current occupancy.
  int phase_cap [PHASES] = '{16, 3, 1, 0, 31, 16, 5, 2, 20, 16, 8};
  int phase_pct [PHASES] = '{80, 40, 50, 60, 85, 50, 45, 70, 65, 30, 55};

  three_class_priority_queue_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_strobe  (out_strobe),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one word to the queue model and returns the result it must give.
  function automatic out_word_t queue_apply(input in_word_t w);
    out_word_t   r;
    cell_entry_t e;
    int          limit;
    int          p;
    r = '0;
    if (w.mode == MODE_INSERT) begin
      e.tag = w.entry_tag;
      e.cls = (w.priority_class > CLASS_LOWEST) ? CLASS_LOWEST : w.priority_class;
      limit = (cap_model > DEPTH) ? DEPTH : int'(cap_model);
      if (queue_model.size() >= limit) begin
        r.status = ST_FULL;
      end else begin
        // The new entry goes behind every entry of equal or higher priority.
        queue_model.push_back(e);
        p = queue_model.size() - 1;
        while (p > 0 && queue_model[p - 1].cls > e.cls) begin
          queue_model[p] = queue_model[p - 1];
          p--;
        end
        queue_model[p] = e;
        r.status = ST_INSERTED;
      end
    end else if (queue_model.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      e = queue_model.pop_front();
      r.status        = ST_REMOVED;
      r.removed_tag   = e.tag;
      r.removed_class = e.cls;
    end
    r.occupancy = OCC_W'(queue_model.size());
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : word_monitor
    out_word_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        cap_model = cfg_wr_data;
      end
      if (out_strobe) begin
        if (result_fifo.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, got %h", $time, out_word);
        end else begin
          want = result_fifo.pop_front();
          check_field("status", 32'(want.status), 32'(out_word.status));
          check_field("removed_tag", 32'(want.removed_tag), 32'(out_word.removed_tag));
          check_field("removed_class", 32'(want.removed_class),
                      32'(out_word.removed_class));
          check_field("occupancy", 32'(want.occupancy), 32'(out_word.occupancy));
        end
      end
      if (start && !busy) begin
        want = queue_apply(in_word);
        if (row_fixed) begin
          want = row_expect;
        end
        result_fifo.push_back(want);
        n_words++;
        case (want.status)
          ST_INSERTED: n_inserted++;
          ST_FULL:     n_refused++;
          ST_REMOVED:  n_removed++;
          default:     n_empty++;
        endcase
      end
      if ((start && !busy) || out_strobe) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(input in_word_t w, input logic fixed, input out_word_t want);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_word    <= w;
    row_fixed  <= fixed;
    row_expect <= want;
    do @(posedge clk); while (busy);
  endtask

  // Called right at an accepting edge; returns once every result word is in.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (result_fifo.size() != 0);
  endtask

  initial begin : stimulus
    in_word_t w;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_word     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 5'd0;
    row_fixed   <= 1'b0;
    row_expect  <= '0;
    idle_on      = 1'b1;
    cap_model    = 5'd16;
    mismatches   = 0;
    stall_cycles = 0;
    n_words      = 0;
    n_inserted   = 0;
    n_refused    = 0;
    n_removed    = 0;
    n_empty      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].want);
    end
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= phase_cap[ph][4:0];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      // Most phases idle at random; the rest run words back to back.
      idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w.mode           = ($urandom_range(0, 99) < phase_pct[ph]) ? MODE_INSERT : MODE_REMOVE;
        w.entry_tag      = TAG_BITS'($urandom());
        w.priority_class = 2'($urandom_range(0, 3));
        send_word(w, 1'b0, '0);
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (result_fifo.size() != 0) begin
      mismatches++;
      $display("%0t: %0d result words never arrived", $time, result_fifo.size());
    end
    $display("Sent %0d words over %0d capacity settings, %0d mismatches.",
             n_words, PHASES + 1, mismatches);
    $display("Results: %0d inserted, %0d refused, %0d removed, %0d on an empty queue.",
             n_inserted, n_refused, n_removed, n_empty);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
